FILE: sv/rtcam_pkg.sv
// Shared types and constants for the RTC alarm matcher and ringer.
package rtcam_pkg;

    // Field widths of one transaction
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned HOUR_W    = 5;
    localparam int unsigned MINUTE_W  = 6;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned WEEKDAY_W = 3;
    localparam int unsigned WMASK_W   = 7;
    localparam int unsigned FIRED_W   = 3;
    localparam int unsigned STEP_W    = 2;
    localparam int unsigned POS_W     = 16;

    // Configuration port
    localparam int unsigned SETUP_W        = 29;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned NUM_SETUP_REGS = 3;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Timing constants in milliseconds
    localparam logic [NOW_W-1:0] RATE_MS       = 32'd1000;
    localparam logic [NOW_W-1:0] RING_LIMIT_MS = 32'd60000;
    localparam logic [POS_W-1:0] CYCLE_MS      = 16'd2000;
    localparam logic [POS_W-1:0] STEP0_END_MS  = 16'd250;
    localparam logic [POS_W-1:0] STEP1_END_MS  = 16'd500;
    localparam logic [POS_W-1:0] STEP2_END_MS  = 16'd750;
    // Conditional subtracts needed to fold an elapsed time up to the limit into one cycle
    localparam int unsigned      FOLD_STEPS    = 5;

    // Clock validity limits
    localparam logic [HOUR_W-1:0]    HOUR_MAX     = 5'd23;
    localparam logic [MINUTE_W-1:0]  MINUTE_MAX   = 6'd59;

    // Tone step codes
    localparam logic [STEP_W-1:0] STEP_LOW  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_MID  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_HIGH = 2'd2;
    localparam logic [STEP_W-1:0] NO_STEP   = 2'd3;

    // Action codes
    localparam logic ACTION_TICK    = 1'b0;
    localparam logic ACTION_DISMISS = 1'b1;

    // Alarm setup register layout
    typedef struct packed {
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic                use_date;
        logic [WMASK_W-1:0]  wmask;
        logic                enable;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
    } setup_t;

    localparam logic [SETUP_W-1:0] SETUP_DEFAULT_0     = 29'd35123207;
    localparam logic [SETUP_W-1:0] SETUP_DEFAULT_1     = 29'd35123212;
    localparam logic [SETUP_W-1:0] SETUP_DEFAULT_2     = 29'd35123218;
    localparam logic [SETUP_W-1:0] SETUP_DEFAULT_EXTRA = 29'd35123200;

    // Input transaction
    typedef struct packed {
        logic                 action;
        logic [NOW_W-1:0]     now_ms;
        logic [HOUR_W-1:0]    clock_hour;
        logic [MINUTE_W-1:0]  clock_minute;
        logic [DAY_W-1:0]     clock_day;
        logic [MONTH_W-1:0]   clock_month;
        logic [WEEKDAY_W-1:0] weekday;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic               check_done;
        logic [FIRED_W-1:0] fired_mask;
        logic               ringing_now;
        logic               tone_start;
        logic [STEP_W-1:0]  tone_step;
        logic               speaker_stop;
    } result_t;

    // Classification of one transaction
    typedef enum logic [1:0] {
        CMD_IDLE,
        CMD_CHECK,
        CMD_DISMISS
    } cmd_kind_t;

    // Command handed from the front to the ringer
    typedef struct packed {
        cmd_kind_t          kind;
        logic [FIRED_W-1:0] fired_mask;
        logic               fire_any;
        logic               over_limit;
        logic [STEP_W-1:0]  step;
    } cmd_t;

    // Queue status seen by the top level and the back
    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    // Reset value of an alarm setup
    function automatic setup_t setup_default(input int unsigned idx);
        setup_t s;
        case (idx)
            0:       s = setup_t'(SETUP_DEFAULT_0);
            1:       s = setup_t'(SETUP_DEFAULT_1);
            2:       s = setup_t'(SETUP_DEFAULT_2);
            default: s = setup_t'(SETUP_DEFAULT_EXTRA);
        endcase
        return s;
    endfunction

endpackage

FILE: sv/rtc_alarm_matcher_ringer.sv
// Top level of the RTC alarm matcher and ringer.
// Accepts one tick or dismiss transaction per clock cycle while item_ready is high, and
// returns exactly one result for each, in order. The front classifies the transaction and
// matches all alarm setups in the accepting cycle, a two-entry command queue registers it,
// and the ringer pops it, updates its state and loads the result register. The front (rate
// gate, parallel alarm compare and a five-step fold of the ring time into the CYCLE_MS
// tone period) is combinational. Back-pressure on the result side fills the queue and then
// drops item_ready. Alarm setups are written through cfg_we, cfg_index and cfg_data;
// indices beyond the last setup are ignored.
module rtc_alarm_matcher_ringer #(
    parameter int unsigned NUM_ALARMS = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  rtcam_pkg::item_t                  item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output rtcam_pkg::result_t                result,
    input  logic                              cfg_we,
    input  logic [rtcam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rtcam_pkg::SETUP_W-1:0]     cfg_data
);
    import rtcam_pkg::*;

    logic      push;
    logic      pop;
    cmd_t      front_cmd;
    cmd_t      head_cmd;
    q_status_t q_stat;

    // Accept a transaction whenever the queue has room
    assign item_ready = !q_stat.full;
    assign push       = item_valid && item_ready;

    rtcam_front #(
        .NUM_ALARMS(NUM_ALARMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (front_cmd)
    );

    rtcam_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .status   (q_stat)
    );

    rtcam_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_stat.valid),
        .cmd          (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    // A full queue always has a command to offer
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> q_stat.valid)
        else $error("queue full without a valid head");

    // A stop never leaves the ringer ringing
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.speaker_stop && result.ringing_now))
        else $error("speaker stop while still ringing");

    // A tone only starts while ringing, with a real step
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.tone_start) |->
            (result.ringing_now && (result.tone_step != NO_STEP)))
        else $error("tone start outside ringing or with no step");

    // A fired alarm comes from a checked tick and leaves the ringer ringing
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.fired_mask != '0)) |->
            (result.check_done && result.ringing_now))
        else $error("alarm fired without a check or without ringing");

    // A popped command is loaded into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> result_valid)
        else $error("popped command did not reach the result register");
`endif

endmodule

FILE: sv/rtcam_front.sv
// Front end: tick rate gate, alarm matching and ring timing classification.
module rtcam_front #(
    parameter int unsigned NUM_ALARMS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  rtcam_pkg::item_t                 item,
    input  logic                             cfg_we,
    input  logic [rtcam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rtcam_pkg::SETUP_W-1:0]    cfg_data,
    output rtcam_pkg::cmd_t                  cmd
);
    import rtcam_pkg::*;

    setup_t                setup_reg [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] marks_reg;
    logic [NUM_ALARMS-1:0] marks_next;
    logic [NOW_W-1:0]      last_check_reg;
    logic [NOW_W-1:0]      ring_start_reg;

    logic [NUM_ALARMS-1:0] fire;
    logic [NUM_ALARMS+FIRED_W-1:0] fire_ext;
    logic                  fire_any;
    logic [NOW_W-1:0]      since_check;
    logic                  tick_ok;
    logic                  time_ok;
    logic                  check;
    logic [NOW_W-1:0]      elapsed;
    logic                  over_limit;
    logic [POS_W-1:0]      pos;
    logic [STEP_W-1:0]     step;

    // Gate ticks on rate and clock validity
    always_comb
    begin
        since_check = item.now_ms - last_check_reg;
        tick_ok     = (item.action == ACTION_TICK) && (since_check >= RATE_MS);
        time_ok     = (item.clock_hour <= HOUR_MAX) && (item.clock_minute <= MINUTE_MAX);
        check       = tick_ok && time_ok;
    end

    // Match every alarm in parallel against the clock
    always_comb
    begin
        logic                 match;
        logic [WMASK_W:0]     wmask_ext;
        logic                 day_ok;
        logic                 date_ok;
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            match     = (setup_reg[i].hour == item.clock_hour) &&
                        (setup_reg[i].minute == item.clock_minute);
            wmask_ext = {1'b0, setup_reg[i].wmask};
            day_ok    = wmask_ext[item.weekday];
            date_ok   = !setup_reg[i].use_date ||
                        ((setup_reg[i].day == item.clock_day) &&
                         (setup_reg[i].month == item.clock_month));
            marks_next[i] = marks_reg[i] && match && setup_reg[i].enable;
            fire[i]       = setup_reg[i].enable && day_ok && date_ok && match && !marks_reg[i];
            if (fire[i])
            begin
                marks_next[i] = 1'b1;
            end
        end
        fire_ext = {{FIRED_W{1'b0}}, fire & {NUM_ALARMS{check}}};
        fire_any = check && (|fire);
    end

    // Work out ring time and the tone step within the CYCLE_MS tone period
    always_comb
    begin
        elapsed    = fire_any ? '0 : (item.now_ms - ring_start_reg);
        over_limit = elapsed > RING_LIMIT_MS;
        pos        = elapsed[POS_W-1:0];
        for (int k = FOLD_STEPS - 1; k >= 0; k--)
        begin
            if (pos >= (CYCLE_MS << k))
            begin
                pos = pos - (CYCLE_MS << k);
            end
        end
        if (pos < STEP0_END_MS)
        begin
            step = STEP_LOW;
        end
        else if (pos < STEP1_END_MS)
        begin
            step = STEP_MID;
        end
        else if (pos < STEP2_END_MS)
        begin
            step = STEP_HIGH;
        end
        else
        begin
            step = NO_STEP;
        end
    end

    // Build the command for the ringer
    always_comb
    begin
        if (item.action == ACTION_DISMISS)
        begin
            cmd.kind = CMD_DISMISS;
        end
        else if (check)
        begin
            cmd.kind = CMD_CHECK;
        end
        else
        begin
            cmd.kind = CMD_IDLE;
        end
        cmd.fired_mask = fire_ext[FIRED_W-1:0];
        cmd.fire_any   = fire_any;
        cmd.over_limit = over_limit;
        cmd.step       = step;
    end

    // Hold the alarm setups; take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                setup_reg[i] <= setup_default(i);
            end
        end
        else
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                if (cfg_we && (i < NUM_SETUP_REGS) && (cfg_index == CFG_INDEX_W'(i)))
                begin
                    setup_reg[i] <= setup_t'(cfg_data);
                end
            end
        end
    end

    // Advance tick time, fired marks and ring start on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_check_reg <= '0;
            ring_start_reg <= '0;
            marks_reg      <= '0;
        end
        else if (push)
        begin
            if (tick_ok)
            begin
                last_check_reg <= item.now_ms;
            end
            if (check)
            begin
                marks_reg <= marks_next;
            end
            if (fire_any)
            begin
                ring_start_reg <= item.now_ms;
            end
        end
    end

endmodule

FILE: sv/rtcam_queue.sv
// Short command queue between the classifying front and the ringer.
module rtcam_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rtcam_pkg::cmd_t      push_cmd,
    input  logic                 pop,
    output rtcam_pkg::cmd_t      head,
    output rtcam_pkg::q_status_t status
);
    import rtcam_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // Present the oldest entry and the fill status
    always_comb
    begin
        head         = entry_reg[rd_ptr_reg];
        status.valid = count_reg != '0;
        status.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/rtcam_back.sv
// Ringer: ringing state, tone steps, dismissals and the result register.
module rtcam_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  rtcam_pkg::cmd_t   cmd,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output rtcam_pkg::result_t result
);
    import rtcam_pkg::*;

    logic              ringing_reg;
    logic              ringing_next;
    logic [STEP_W-1:0] last_step_reg;
    logic [STEP_W-1:0] last_step_next;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           res;

    // Take the next command whenever the result register is free or drains
    assign pop = q_valid && (!out_valid_reg || result_ready);

    // Carry out one command
    always_comb
    begin
        ringing_next   = ringing_reg;
        last_step_next = last_step_reg;
        res            = '0;
        case (cmd.kind)
            CMD_DISMISS:
            begin
                ringing_next     = 1'b0;
                last_step_next   = NO_STEP;
                res.speaker_stop = 1'b1;
            end
            CMD_CHECK:
            begin
                res.check_done = 1'b1;
                res.fired_mask = cmd.fired_mask;
                if (cmd.fire_any)
                begin
                    ringing_next = 1'b1;
                end
                if (ringing_next)
                begin
                    if (cmd.over_limit)
                    begin
                        ringing_next     = 1'b0;
                        last_step_next   = NO_STEP;
                        res.speaker_stop = 1'b1;
                    end
                    else if (cmd.step == NO_STEP)
                    begin
                        last_step_next = NO_STEP;
                    end
                    else if (cmd.step != last_step_reg)
                    begin
                        last_step_next = cmd.step;
                        res.tone_start = 1'b1;
                        res.tone_step  = cmd.step;
                    end
                end
            end
            CMD_IDLE:
            begin
                res.check_done = 1'b0;
            end
            default:
            begin
                res.check_done = 1'b0;
            end
        endcase
        res.ringing_now = ringing_next;
    end

    // Update ringer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ringing_reg   <= 1'b0;
            last_step_reg <= NO_STEP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                ringing_reg   <= ringing_next;
                last_step_reg <= last_step_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
